[hw/rtl/heston_euler_path_step_unit_assert.svh]
// Assertion macros for the Heston path step unit
`ifndef HESTON_EULER_PATH_STEP_UNIT_ASSERT_SVH
`define HESTON_EULER_PATH_STEP_UNIT_ASSERT_SVH
// implication checked on every edge out of reset
`define HPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// consequence in the next cycle
`define HPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

[hw/rtl/hps_pkg.sv]
// Shared types and codes for the Heston path step unit
package hps_pkg;
	localparam int W = 32;
	localparam int F = 24;

	// register indexes
	localparam logic [2:0] REG_DT = 3'd0;
	localparam logic [2:0] REG_DRIFT = 3'd1;
	localparam logic [2:0] REG_KAPPA = 3'd2;
	localparam logic [2:0] REG_THETA = 3'd3;
	localparam logic [2:0] REG_XI = 3'd4;
	localparam logic [2:0] REG_RHO = 3'd5;
	localparam logic [2:0] REG_V0 = 3'd6;
	localparam logic [2:0] REG_LS0 = 3'd7;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,     // fresh path load of initial values
		OP_VP,       // vp = max(v,0), start sqrt(vp)
		OP_SQRT_DT,  // start sqrt(dt)
		OP_RHO2,     // t = rho*rho
		OP_ORTH,     // start sqrt(1 - t), clamped at zero
		OP_SD,       // sd = sv*root
		OP_ZS1,      // a = rho*zv
		OP_ZS2,      // zs = a + orth*zi
		OP_HALF,     // h = (vp*dt)>>1
		OP_LS1,      // ls = ls+drift, ls -= h
		OP_LS2,      // ls += sd*zs
		OP_K1,       // a = kappa*(theta-vp)
		OP_K2,       // vn = v + a*dt
		OP_X1,       // a = xi*sd
		OP_X2,       // vn += a*zv, commit
		OP_ROOT_WB,  // root <= sqrt result
		OP_ORTH_WB,  // orth <= sqrt result
		OP_SV_WB     // sv <= sqrt result
	} op_t;

	typedef struct packed {
		op_t op;
		logic take;  // capture the input samples of an accepted beat
	} cmd_t;

	typedef struct packed {
		logic sqrt_busy;
	} stat_t;

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		return s[W-1:0];
	endfunction
endpackage

[hw/rtl/heston_euler_path_step_unit.sv]
// Heston full-truncation Euler path step unit, top level
// An accepted input beat runs one Euler step; on a last step the result beat follows in S_OUT.
// A new input beat is taken only once the step before it is through; the serial square
// root of the variance and the dependent multiply and add steps set the pace.
// A write to step_length or correlation adds a sqrt update before the
// next item. Reset (arst_n low) zeroes registers and path state, orthogonal weight one.
module heston_euler_path_step_unit import hps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] z_variance,
	input  logic signed [31:0] z_independent,
	input  logic               last_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] end_log_spot,
	output logic signed [31:0] end_variance
);
	cmd_t cmd;
	stat_t stat;
	logic cap_out, cfg_we;
	logic signed [31:0] ls_w, v_w;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'b00);

	hps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_last(last_step), .out_valid(out_valid), .out_ready(out_ready),
		.cfg_we(cfg_we), .cfg_idx(paddr[4:2]), .stat(stat), .cmd(cmd),
		.cap_out(cap_out)
	);

	hps_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_idx(paddr[4:2]), .cfg_data(pwdata), .cfg_rd(prdata),
		.rd_idx(paddr[4:2]), .zv_in(z_variance), .zi_in(z_independent),
		.ls_out(ls_w), .v_out(v_w)
	);

	// output register: final state sampled once the last step has committed
	always_ff @(posedge clk) begin
		if (cap_out) begin
			end_log_spot <= ls_w;
			end_variance <= v_w;
		end
	end
endmodule

[hw/rtl/hps_sqrt.sv]
// Bit-serial integer square root of x << F, one result bit per cycle
module hps_sqrt import hps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] x,
	output logic                busy,
	output logic signed [W-1:0] root
);
	localparam int RB = (W + F + 1) / 2 + 1;
	localparam int NB = 2 * RB;
	localparam int CB = $clog2(RB + 1);

	logic [NB-1:0] rem_q, num_q;
	logic [RB-1:0] res_q;
	logic [CB-1:0] cnt_q;
	logic [NB-1:0] trial;
	logic [NB-1:0] rem_sh;

	// restoring method: bring down two bits, try 4r+1
	always_comb begin
		rem_sh = {rem_q[NB-3:0], num_q[NB-1:NB-2]};
		trial = {{(NB-RB-2){1'b0}}, res_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= CB'(RB);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CB'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			res_q <= '0;
			num_q <= x[W-1] ? '0 : (NB'(x) << F);
		end else if (busy) begin
			num_q <= num_q << 2;
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				res_q <= {res_q[RB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				res_q <= {res_q[RB-2:0], 1'b0};
			end
		end
	end

	// saturate to the positive word range
	always_comb begin
		if (res_q > RB'({1'b0, {(W-1){1'b1}}})) root = {1'b0, {(W-1){1'b1}}};
		else root = W'(res_q);
	end
endmodule

[hw/rtl/hps_datapath.sv]
// Datapath: registers, state, one multiplier, adder and the sqrt unit
module hps_datapath import hps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [31:0]         cfg_data,
	output logic [31:0]         cfg_rd,
	input  logic [2:0]          rd_idx,
	input  logic signed [31:0]  zv_in,
	input  logic signed [31:0]  zi_in,
	output logic signed [31:0]  ls_out,
	output logic signed [31:0]  v_out
);
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< F);

	logic signed [W-1:0] dt_q, drift_q, kappa_q, theta_q, xi_q, rho_q, v0_q, ls0_q;
	logic signed [W-1:0] ls_q, v_q, root_q, orth_q;
	logic signed [W-1:0] vp_q, sv_q, sd_q, zs_q, a_q, h_q, vn_q, t_q, zv_q, zi_q;
	logic signed [W-1:0] ma, mb, mp;
	logic signed [W-1:0] sq_x, sq_r;
	logic sq_start;

	// fixed point multiply: magnitudes, truncate, sign, saturate
	logic [W-1:0] mag_a, mag_b;
	logic [2*W-1:0] prod;
	logic [2*W-1:0] shp;
	logic neg;
	always_comb begin
		neg = ma[W-1] ^ mb[W-1];
		mag_a = ma[W-1] ? W'(-ma) : W'(ma);
		mag_b = mb[W-1] ? W'(-mb) : W'(mb);
		prod = mag_a * mag_b;
		shp = prod >> F;
		if (!neg) mp = (shp > (2*W)'(MAXV)) ? MAXV : W'(shp);
		else if (shp >= (2*W)'({1'b0, MAXV}) + 1) mp = MINV;
		else mp = -W'(shp);
	end

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_RHO2: begin ma = rho_q; mb = rho_q; end
			OP_SD: begin ma = sv_q; mb = root_q; end
			OP_ZS1: begin ma = rho_q; mb = zv_q; end
			OP_ZS2: begin ma = orth_q; mb = zi_q; end
			OP_HALF: begin ma = vp_q; mb = dt_q; end
			OP_LS2: begin ma = sd_q; mb = zs_q; end
			OP_K1: begin ma = kappa_q; mb = sat_add(theta_q, -vp_q); end
			OP_K2: begin ma = a_q; mb = dt_q; end
			OP_X1: begin ma = xi_q; mb = sd_q; end
			OP_X2: begin ma = a_q; mb = zv_q; end
			default: ;
		endcase
	end

	logic signed [W-1:0] orth_d;
	always_comb begin
		orth_d = sat_add(ONE, -t_q);
		if (orth_d[W-1]) orth_d = '0;
		sq_start = 1'b0;
		sq_x = '0;
		case (cmd.op)
			OP_VP: begin sq_start = 1'b1; sq_x = v_q[W-1] ? '0 : v_q; end
			OP_SQRT_DT: begin sq_start = 1'b1; sq_x = dt_q; end
			OP_ORTH: begin sq_start = 1'b1; sq_x = orth_d; end
			default: ;
		endcase
	end

	hps_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .x(sq_x),
		.busy(stat.sqrt_busy), .root(sq_r)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= '0; drift_q <= '0; kappa_q <= '0; theta_q <= '0;
			xi_q <= '0; rho_q <= '0; v0_q <= '0; ls0_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DT: dt_q <= W'({7'd0, cfg_data[24:0]});
				REG_DRIFT: drift_q <= W'(signed'(cfg_data));
				REG_KAPPA: kappa_q <= W'({1'b0, cfg_data[30:0]});
				REG_THETA: theta_q <= W'({1'b0, cfg_data[30:0]});
				REG_XI: xi_q <= W'({1'b0, cfg_data[30:0]});
				REG_RHO: rho_q <= W'(signed'(cfg_data[25:0]));
				REG_V0: v0_q <= W'({1'b0, cfg_data[30:0]});
				REG_LS0: ls0_q <= W'(signed'(cfg_data));
				default: ;
			endcase
		end
	end

	always_comb begin
		case (rd_idx)
			REG_DT: cfg_rd = {7'd0, dt_q[24:0]};
			REG_DRIFT: cfg_rd = drift_q;
			REG_KAPPA: cfg_rd = kappa_q;
			REG_THETA: cfg_rd = theta_q;
			REG_XI: cfg_rd = xi_q;
			REG_RHO: cfg_rd = {{6{rho_q[25]}}, rho_q[25:0]};
			REG_V0: cfg_rd = v0_q;
			REG_LS0: cfg_rd = ls0_q;
			default: cfg_rd = '0;
		endcase
	end

	// path state and step scratch registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q <= '0; v_q <= '0; root_q <= '0; orth_q <= ONE;
		end else begin
			case (cmd.op)
				OP_LOAD: begin ls_q <= ls0_q; v_q <= v0_q; end
				OP_LS1: ls_q <= sat_add(sat_add(ls_q, drift_q), -h_q);
				OP_LS2: ls_q <= sat_add(ls_q, mp);
				OP_X2: v_q <= sat_add(vn_q, mp);
				OP_ROOT_WB: root_q <= sq_r;
				OP_ORTH_WB: orth_q <= sq_r;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// samples are held from the accepting edge on
		if (cmd.take) begin
			zv_q <= zv_in;
			zi_q <= zi_in;
		end
		case (cmd.op)
			OP_VP: vp_q <= v_q[W-1] ? '0 : v_q;
			OP_RHO2: t_q <= mp;
			OP_SV_WB: sv_q <= sq_r;
			OP_SD: sd_q <= mp;
			OP_ZS1: a_q <= mp;
			OP_ZS2: zs_q <= sat_add(a_q, mp);
			OP_HALF: h_q <= W'(mp >>> 1);
			OP_K1: a_q <= mp;
			OP_K2: vn_q <= sat_add(v_q, mp);
			OP_X1: a_q <= mp;
			default: ;
		endcase
	end

	assign ls_out = ls_q;
	assign v_out = v_q;
endmodule

[hw/rtl/hps_ctrl.sv]
// Controller: sequences one Euler step and the derived-value updates
module hps_ctrl import hps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic       cfg_we,
	input  logic [2:0] cfg_idx,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       cap_out
);
	typedef enum logic [4:0] {
		S_IDLE, S_VP, S_VPW, S_SVWB, S_SD, S_ZS1, S_ZS2, S_HALF, S_LS1, S_LS2,
		S_K1, S_K2, S_X1, S_X2, S_OUT, S_DT, S_DTW, S_DTWB, S_R2, S_OR, S_ORW, S_ORWB
	} state_t;

	state_t state_q;
	logic fresh_q, last_q, dt_pend_q, rho_pend_q;
	logic out_free;

	assign in_ready = (state_q == S_IDLE) && !dt_pend_q && !rho_pend_q && !cfg_we;
	// the output register may take a new result
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd.op = OP_NONE;
		cmd.take = 1'b0;
		cap_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.take = in_valid && in_ready;
				if (in_valid && in_ready && fresh_q) cmd.op = OP_LOAD;
			end
			S_VP: cmd.op = OP_VP;
			S_SVWB: cmd.op = OP_SV_WB;
			S_SD: cmd.op = OP_SD;
			S_ZS1: cmd.op = OP_ZS1;
			S_ZS2: cmd.op = OP_ZS2;
			S_HALF: cmd.op = OP_HALF;
			S_LS1: cmd.op = OP_LS1;
			S_LS2: cmd.op = OP_LS2;
			S_K1: cmd.op = OP_K1;
			S_K2: cmd.op = OP_K2;
			S_X1: cmd.op = OP_X1;
			S_X2: cmd.op = OP_X2;
			S_OUT: cap_out = out_free;
			S_DT: cmd.op = OP_SQRT_DT;
			S_DTWB: cmd.op = OP_ROOT_WB;
			S_R2: cmd.op = OP_RHO2;
			S_OR: cmd.op = OP_ORTH;
			S_ORWB: cmd.op = OP_ORTH_WB;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fresh_q <= 1'b1;
			last_q <= 1'b0;
			dt_pend_q <= 1'b0;
			rho_pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == REG_DT) dt_pend_q <= 1'b1;
			if (cfg_we && cfg_idx == REG_RHO) rho_pend_q <= 1'b1;
			// result beat: set on capture, cleared on accept
			if (state_q == S_OUT && out_free) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						fresh_q <= 1'b0;
						last_q <= in_last;
						state_q <= S_VP;
					end else if (!cfg_we && dt_pend_q) begin
						dt_pend_q <= 1'b0;
						state_q <= S_DT;
					end else if (!cfg_we && rho_pend_q) begin
						rho_pend_q <= 1'b0;
						state_q <= S_R2;
					end
				end
				S_VP: state_q <= S_VPW;
				S_VPW: if (!stat.sqrt_busy) state_q <= S_SVWB;
				S_SVWB: state_q <= S_SD;
				S_SD: state_q <= S_ZS1;
				S_ZS1: state_q <= S_ZS2;
				S_ZS2: state_q <= S_HALF;
				S_HALF: state_q <= S_LS1;
				S_LS1: state_q <= S_LS2;
				S_LS2: state_q <= S_K1;
				S_K1: state_q <= S_K2;
				S_K2: state_q <= S_X1;
				S_X1: state_q <= S_X2;
				S_X2: state_q <= last_q ? S_OUT : S_IDLE;
				S_OUT: begin
					if (out_free) begin
						fresh_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DT: state_q <= S_DTW;
				S_DTW: if (!stat.sqrt_busy) state_q <= S_DTWB;
				S_DTWB: state_q <= S_IDLE;
				S_R2: state_q <= S_OR;
				S_OR: state_q <= S_ORW;
				S_ORW: if (!stat.sqrt_busy) state_q <= S_ORWB;
				S_ORWB: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "heston_euler_path_step_unit_assert.svh"
	`HPS_ASSERT_IMP(a_ready_idle, in_ready, state_q == S_IDLE)
	`HPS_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == S_VP)
	`HPS_ASSERT_NEXT(a_out_after_last, cap_out, out_valid && fresh_q)
	`HPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

[tb/heston_euler_path_step_unit_test.sv]
// Testbench for the Heston full-truncation Euler path step unit
`timescale 1ns / 1ps
module heston_euler_path_step_unit_test;
	import hps_pkg::*;

	localparam longint MAXW = 64'sd2147483647;
	localparam longint MINW = -64'sd2147483648;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		logic signed [31:0] zv;
		logic signed [31:0] zi;
		logic last;
	} step_item_t;

	typedef struct {
		logic signed [31:0] ls;
		logic signed [31:0] v;
	} path_end_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, last_step;
	logic signed [31:0] z_variance, z_independent;
	logic out_valid, out_ready;
	logic signed [31:0] end_log_spot, end_variance;

	step_item_t pending_steps[$];
	path_end_t expected_ends[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int in_gap = 0;
	int out_gap = 0;

	// predictor copy of registers and path state
	longint m_dt, m_drift, m_kappa, m_theta, m_xi, m_rho, m_v0, m_ls0;
	longint m_ls, m_v, m_root, m_orth;
	bit m_fresh;

	heston_euler_path_step_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.z_variance(z_variance), .z_independent(z_independent), .last_step(last_step),
		.out_valid(out_valid), .out_ready(out_ready),
		.end_log_spot(end_log_spot), .end_variance(end_variance)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clampw(longint a);
		if (a > MAXW) return MAXW;
		if (a < MINW) return MINW;
		return a;
	endfunction

	function automatic longint sat_sum(longint a, longint b);
		return clampw(a + b);
	endfunction

	// fixed-point product: truncate magnitude, then saturate
	function automatic longint fx_mul(longint a, longint b);
		bit neg;
		longint unsigned ma, mb, m, lim;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		m = (ma * mb) >> F;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		if (m > lim) m = lim;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// floor sqrt of x << F, bit by bit
	function automatic longint fx_sqrt(longint x);
		longint unsigned xv, r, c;
		if (x <= 0) return 0;
		xv = longint'(x) << F;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= xv) r = c;
		end
		return longint'(r);
	endfunction

	function automatic longint ortho_weight(longint rho);
		longint d;
		d = sat_sum(64'sd16777216, -fx_mul(rho, rho));
		return fx_sqrt(d < 0 ? 0 : d);
	endfunction

	// advance the predicted path by one step, queue the end values on a last step
	task automatic advance_path(input step_item_t it);
		longint zv, zi, vp, sd, zs, half, ls, v;
		path_end_t e;
		zv = longint'(it.zv);
		zi = longint'(it.zi);
		if (m_fresh) begin
			m_ls = m_ls0;
			m_v = m_v0;
			m_fresh = 0;
		end
		vp = m_v > 0 ? m_v : 0;
		sd = fx_mul(fx_sqrt(vp), m_root);
		zs = sat_sum(fx_mul(m_rho, zv), fx_mul(m_orth, zi));
		half = fx_mul(vp, m_dt) >>> 1;
		ls = sat_sum(m_ls, m_drift);
		ls = sat_sum(ls, -half);
		ls = sat_sum(ls, fx_mul(sd, zs));
		v = sat_sum(m_v, fx_mul(fx_mul(m_kappa, sat_sum(m_theta, -vp)), m_dt));
		v = sat_sum(v, fx_mul(fx_mul(m_xi, sd), zv));
		m_ls = ls;
		m_v = v;
		if (it.last) begin
			e.ls = m_ls[31:0];
			e.v = m_v[31:0];
			expected_ends.insert(expected_ends.size(), e);
			m_fresh = 1;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// register write: setup beat then access beat
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DT: begin m_dt = val & 32'h1FFFFFF; m_root = fx_sqrt(m_dt); end
			REG_DRIFT: m_drift = longint'(signed'(val));
			REG_KAPPA: m_kappa = val & 32'h7FFFFFFF;
			REG_THETA: m_theta = val & 32'h7FFFFFFF;
			REG_XI: m_xi = val & 32'h7FFFFFFF;
			REG_RHO: begin
				m_rho = longint'(signed'(val[25:0]));
				m_orth = ortho_weight(m_rho);
			end
			REG_V0: m_v0 = val & 32'h7FFFFFFF;
			REG_LS0: m_ls0 = longint'(signed'(val));
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] dt, input logic [31:0] drift,
			input logic [31:0] kappa, input logic [31:0] theta, input logic [31:0] xi,
			input logic [31:0] rho, input logic [31:0] v0, input logic [31:0] ls0);
		reg_write(REG_DT, dt);
		reg_write(REG_DRIFT, drift);
		reg_write(REG_KAPPA, kappa);
		reg_write(REG_THETA, theta);
		reg_write(REG_XI, xi);
		reg_write(REG_RHO, rho);
		reg_write(REG_V0, v0);
		reg_write(REG_LS0, ls0);
	endtask

	task automatic queue_step(input logic [31:0] zv, input logic [31:0] zi, input logic last);
		step_item_t it;
		it.zv = zv;
		it.zi = zi;
		it.last = last;
		pending_steps.insert(pending_steps.size(), it);
	endtask

	// normal-looking sample, now and then a full-range word
	function automatic logic [31:0] rand_z();
		if ($urandom_range(9) == 0) return $urandom;
		return 32'($signed($urandom_range(32'h8000000)) - 32'sh4000000);
	endfunction

	// wait for the block to drain, then let it settle
	task automatic drain();
		wait (pending_steps.size() == 0 && expected_ends.size() == 0 && !in_valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_paths(input int count);
		int n;
		n = 0;
		while (n < count) begin
			int len;
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
			for (int k = 0; k < len; k++) begin
				queue_step(rand_z(), rand_z(), (k == len - 1) ? 1'b1 : 1'b0);
				n++;
			end
		end
	endtask

	// sender: one beat per accept, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			z_variance <= '0;
			z_independent <= '0;
			last_step <= 1'b0;
			in_gap <= 0;
		end else begin
			step_item_t it;
			logic nv;
			nv = in_valid;
			if (in_valid && in_ready) begin
				it.zv = z_variance;
				it.zi = z_independent;
				it.last = last_step;
				advance_path(it);
				nv = 1'b0;
			end
			if (!nv) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
				end else if (pending_steps.size() > 0) begin
					it = pending_steps.pop_front();
					z_variance <= it.zv;
					z_independent <= it.zi;
					last_step <= it.last;
					nv = 1'b1;
					in_gap <= pick_gap();
				end
			end
			in_valid <= nv;
		end
	end

	// receiver: compare each result beat with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_ends.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result ls=%h v=%h", end_log_spot, end_variance);
				end else begin
					path_end_t e;
					e = expected_ends.pop_front();
					if (e.ls !== end_log_spot || e.v !== end_variance) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: ls exp %h got %h, v exp %h got %h",
								e.ls, end_log_spot, e.v, end_variance);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(3) == 0) out_gap <= pick_gap();
			end
		end
	end

	// watchdog on cycles without any accepted beat or register write
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		m_dt = 0; m_drift = 0; m_kappa = 0; m_theta = 0;
		m_xi = 0; m_rho = 0; m_v0 = 0; m_ls0 = 0;
		m_ls = 0; m_v = 0; m_fresh = 1;
		m_root = fx_sqrt(0);
		m_orth = ortho_weight(0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: zero coefficients, unit orthogonal weight
		queue_step(32'h7FFFFFFF, 32'h80000000, 1'b1);
		queue_step(32'h01000000, 32'hFF000000, 1'b0);
		queue_step(32'h00000000, 32'h00000000, 1'b1);
		drain();

		// typical market setup, directed extremes of the samples
		write_all(32'h00100000, 32'h00004000, 32'h02000000, 32'h00051EB8,
			32'h00800000, 32'hFF4CCCCD, 32'h00051EB8, 32'h049A5AB0);
		queue_step(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
		queue_step(32'h80000000, 32'h80000000, 1'b1);
		queue_step(32'h80000000, 32'h7FFFFFFF, 1'b0);
		queue_step(32'h7FFFFFFF, 32'h80000000, 1'b1);
		queue_step(32'h00000000, 32'hFFFFFFFF, 1'b1);
		// strong down moves in variance drive it negative; truncation takes over
		for (int k = 0; k < 5; k++) queue_step(32'hFC000000, 32'h01000000, k == 4);
		drain();

		// full correlation, huge vol of vol: stored variance goes negative
		write_all(32'h01000000, 32'h80000000, 32'h7FFFFFFF, 32'h00000000,
			32'h7FFFFFFF, 32'h01000000, 32'h7FFFFFFF, 32'h80000000);
		queue_step(32'h01000000, 32'h7FFFFFFF, 1'b0);
		queue_step(32'h80000000, 32'h00000000, 1'b0);
		queue_step(32'h7FFFFFFF, 32'h80000000, 1'b1);
		queue_step(32'h00000000, 32'h00000000, 1'b1);
		drain();
		write_all(32'h01000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'hFF000000, 32'h00000000, 32'h7FFFFFFF);
		queue_step(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
		queue_step(32'h80000000, 32'h80000000, 1'b1);
		queue_step(32'h12345678, 32'hEDCBA987, 1'b1);
		drain();

		// all-zero, full-scale, then random configurations, sender pauses for the drain at each boundary
		for (int p = 0; p < 10; p++) begin
			if (p == 0) begin
				write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
			end else if (p == 1) begin
				write_all(32'h01000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
					32'h7FFFFFFF, 32'h01000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
			end else begin
				write_all($urandom_range(32'h01000000), $urandom_range(32'h00100000),
					$urandom_range(32'h08000000), $urandom_range(32'h01000000),
					$urandom_range(32'h04000000),
					32'($signed($urandom_range(32'h02000000)) - 32'sh01000000),
					$urandom_range(32'h01000000), $urandom);
			end
			random_paths(52);
			drain();
		end

		if (mismatches == 0 && expected_ends.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/hps_pkg.sv
hw/rtl/hps_sqrt.sv
hw/rtl/hps_datapath.sv
hw/rtl/hps_ctrl.sv
hw/rtl/heston_euler_path_step_unit.sv
tb/heston_euler_path_step_unit_test.sv
